[rtl/drp_pkg.sv]
// Shared types, constants and helpers for the dead reckoning pose predictor.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package drp_pkg;

    // Width of the CORDIC x, y and z datapath, Q2.30 values with guard bits.
    localparam int CW = 34;

    // 2^64 / (2*pi) as two 32-bit halves, used for the heading phase.
    localparam logic [31:0] INV_2PI_HI = 32'h28BE_60DB;
    localparam logic [31:0] INV_2PI_LO = 32'h9391_054A;

    // round(pi/2 * 2^30) and round(0.6072529350 * 2^30).
    localparam logic signed [31:0]   PI_HALF_Q30     = 32'sd1686629713;
    localparam logic signed [CW-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;

    // One eighth of a turn in phase units, used to center the quadrants.
    localparam logic [31:0] EIGHTH_TURN = 32'h2000_0000;

    // Rounding term for the rotated displacement in Q2.30.
    localparam logic signed [CW+32:0] ROT_HALF = (CW + 33)'(1) <<< 29;

    // floor(atan(2^-i) * 2^30) for i = 0 .. 31.
    localparam logic [30:0] ATAN_Q30 [32] = '{
        31'd843314856, 31'd497837829, 31'd263043836, 31'd133525158,
        31'd67021686,  31'd33543515,  31'd16775850,  31'd8388437,
        31'd4194282,   31'd2097149,   31'd1048575,   31'd524287,
        31'd262143,    31'd131071,    31'd65535,     31'd32767,
        31'd16383,     31'd8191,      31'd4095,      31'd2047,
        31'd1023,      31'd511,       31'd255,       31'd127,
        31'd63,        31'd31,        31'd15,        31'd8,
        31'd4,         31'd2,         31'd1,         31'd0
    };

    // Quadrant of the heading, centered on the axes.
    typedef enum logic [1:0] {
        QUAD_0   = 2'd0,
        QUAD_90  = 2'd1,
        QUAD_180 = 2'd2,
        QUAD_270 = 2'd3
    } quad_t;

    // One input beat.
    typedef struct packed {
        logic signed [31:0] pose_x;
        logic signed [31:0] pose_y;
        logic signed [31:0] pose_heading;
        logic signed [31:0] body_vel_x;
        logic signed [31:0] body_vel_y;
        logic signed [31:0] body_vel_turn;
        logic        [30:0] time_step;
    } pose_in_t;

    // One result beat.
    typedef struct packed {
        logic signed [31:0] new_x;
        logic signed [31:0] new_y;
        logic signed [31:0] new_heading;
        logic               overflow;
    } pose_out_t;

    // Values that ride along the CORDIC chain with each item.
    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] nh;
        logic signed [31:0] dx;
        logic signed [31:0] dy;
        quad_t              quad;
        logic               ovf;
    } carry_t;

    // State handed from one CORDIC cell to the next.
    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        carry_t               carry;
    } cordic_t;

    // Saturated 32-bit value with its overflow mark.
    typedef struct packed {
        logic               of;
        logic signed [31:0] val;
    } sat_t;

    // Clamp a wide signed value to the 32-bit signed range.
    function automatic sat_t sat32(input logic signed [63:0] v);
        sat_t r;
        if (v > 64'sd2147483647) begin
            r.of  = 1'b1;
            r.val = 32'sh7FFF_FFFF;
        end
        else if (v < -64'sd2147483648) begin
            r.of  = 1'b1;
            r.val = 32'sh8000_0000;
        end
        else begin
            r.of  = 1'b0;
            r.val = v[31:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/drp_front.sv]
// Front end of the pose predictor: velocity scaling, heading range reduction
// and CORDIC seed. Four register stages. Depends on drp_pkg.
`default_nettype none

module drp_front
    import drp_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     en,
    input  wire logic     in_valid,
    input  wire pose_in_t in_data,
    output logic          out_valid,
    output cordic_t       out_data
);

    localparam logic signed [63:0] HALF_LSB = 64'sd1 <<< (FRAC_BITS - 1);

    // Stage 1: velocity times interval, and heading magnitude times 1/(2*pi).
    logic signed [62:0] s1_mvx_next, s1_mvy_next, s1_mvt_next;
    logic signed [62:0] s1_mvx_reg, s1_mvy_reg, s1_mvt_reg;
    logic        [31:0] s1_mag;
    logic        [63:0] s1_p0_next, s1_p1_next, s1_p0_reg, s1_p1_reg;
    logic               s1_neg_reg;
    logic signed [31:0] s1_px_reg, s1_py_reg, s1_ph_reg;
    logic               s1_valid_reg;

    always_comb
    begin
        s1_mag = in_data.pose_heading[31] ? (~in_data.pose_heading + 32'd1)
                                          : in_data.pose_heading;
        s1_mvx_next = in_data.body_vel_x    * $signed({1'b0, in_data.time_step});
        s1_mvy_next = in_data.body_vel_y    * $signed({1'b0, in_data.time_step});
        s1_mvt_next = in_data.body_vel_turn * $signed({1'b0, in_data.time_step});
        s1_p0_next  = s1_mag * INV_2PI_LO;
        s1_p1_next  = s1_mag * INV_2PI_HI;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_mvx_reg <= s1_mvx_next;
            s1_mvy_reg <= s1_mvy_next;
            s1_mvt_reg <= s1_mvt_next;
            s1_p0_reg  <= s1_p0_next;
            s1_p1_reg  <= s1_p1_next;
            s1_neg_reg <= in_data.pose_heading[31];
            s1_px_reg  <= in_data.pose_x;
            s1_py_reg  <= in_data.pose_y;
            s1_ph_reg  <= in_data.pose_heading;
        end
    end

    // Stage 2: rounded scaled velocities and the signed 32-bit phase.
    logic signed [63:0] s2_rx_next, s2_ry_next, s2_rh_next;
    logic signed [63:0] s2_rx_reg, s2_ry_reg, s2_rh_reg;
    logic        [95:0] s2_sum;
    logic        [31:0] s2_mag_phase;
    logic        [31:0] s2_phase_next, s2_phase_reg;
    logic signed [31:0] s2_px_reg, s2_py_reg, s2_ph_reg;
    logic               s2_valid_reg;

    always_comb
    begin
        s2_rx_next = ($signed({s1_mvx_reg[62], s1_mvx_reg}) + HALF_LSB) >>> FRAC_BITS;
        s2_ry_next = ($signed({s1_mvy_reg[62], s1_mvy_reg}) + HALF_LSB) >>> FRAC_BITS;
        s2_rh_next = ($signed({s1_mvt_reg[62], s1_mvt_reg}) + HALF_LSB) >>> FRAC_BITS;
        s2_sum        = {s1_p1_reg, 32'd0} + {32'd0, s1_p0_reg};
        s2_mag_phase  = s2_sum[32 + FRAC_BITS +: 32];
        s2_phase_next = s1_neg_reg ? (32'd0 - s2_mag_phase) : s2_mag_phase;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_rx_reg    <= s2_rx_next;
            s2_ry_reg    <= s2_ry_next;
            s2_rh_reg    <= s2_rh_next;
            s2_phase_reg <= s2_phase_next;
            s2_px_reg    <= s1_px_reg;
            s2_py_reg    <= s1_py_reg;
            s2_ph_reg    <= s1_ph_reg;
        end
    end

    // Stage 3: saturate the displacement and heading, split off the quadrant.
    sat_t               s3_satx, s3_saty, s3_sath;
    logic        [31:0] s3_shifted;
    quad_t              s3_quad;
    carry_t             s3_carry_next, s3_carry_reg;
    logic signed [31:0] s3_r_next, s3_r_reg;
    logic               s3_valid_reg;

    always_comb
    begin
        s3_satx    = sat32(s2_rx_reg);
        s3_saty    = sat32(s2_ry_reg);
        s3_sath    = sat32(s2_ph_reg + s2_rh_reg);
        s3_shifted = s2_phase_reg + EIGHTH_TURN;
        s3_quad    = quad_t'(s3_shifted[31:30]);
        s3_r_next  = $signed(s2_phase_reg - {s3_shifted[31:30], 30'd0});
        s3_carry_next.px   = s2_px_reg;
        s3_carry_next.py   = s2_py_reg;
        s3_carry_next.nh   = s3_sath.val;
        s3_carry_next.dx   = s3_satx.val;
        s3_carry_next.dy   = s3_saty.val;
        s3_carry_next.quad = s3_quad;
        s3_carry_next.ovf  = s3_satx.of | s3_saty.of | s3_sath.of;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_carry_reg <= s3_carry_next;
            s3_r_reg     <= s3_r_next;
        end
    end

    // Stage 4: residual turn to a Q2.30 angle, and the CORDIC seed.
    logic signed [63:0] s4_zprod, s4_zshift;
    cordic_t            s4_data_next, s4_data_reg;
    logic               s4_valid_reg;

    always_comb
    begin
        s4_zprod  = s3_r_reg * PI_HALF_Q30;
        s4_zshift = s4_zprod >>> 30;
        s4_data_next.x     = CORDIC_GAIN_Q30;
        s4_data_next.y     = '0;
        s4_data_next.z     = s4_zshift[CW-1:0];
        s4_data_next.carry = s3_carry_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_data_reg <= s4_data_next;
        end
    end

    // Valid bits of the four stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    assign out_valid = s4_valid_reg;
    assign out_data  = s4_data_reg;

endmodule

`default_nettype wire

[rtl/drp_cordic_cell.sv]
// One CORDIC rotation cell: a single micro-rotation by atan(2^-STEP).
// Depends on drp_pkg.
`default_nettype none

module drp_cordic_cell
    import drp_pkg::*;
#(
    parameter int STEP = 0
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    en,
    input  wire logic    in_valid,
    input  wire cordic_t in_data,
    output logic         out_valid,
    output cordic_t      out_data
);

    logic signed [CW-1:0] x_in, y_in, z_in, xs, ys, atan_step;
    cordic_t              data_next, data_reg;
    logic                 valid_reg;

    // Rotate toward zero residual angle.
    always_comb
    begin
        x_in      = in_data.x;
        y_in      = in_data.y;
        z_in      = in_data.z;
        xs        = x_in >>> STEP;
        ys        = y_in >>> STEP;
        atan_step = $signed({{(CW - 31){1'b0}}, ATAN_Q30[5'(STEP)]});
        data_next.carry = in_data.carry;
        if (!z_in[CW-1])
        begin
            data_next.x = x_in - ys;
            data_next.y = y_in + xs;
            data_next.z = z_in - atan_step;
        end
        else
        begin
            data_next.x = x_in + ys;
            data_next.y = y_in - xs;
            data_next.z = z_in + atan_step;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

[rtl/drp_back.sv]
// Back end of the pose predictor: quadrant mapping, rotation of the
// displacement, saturating update and the result register. Depends on drp_pkg.
`default_nettype none

module drp_back
    import drp_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    en,
    input  wire logic    in_valid,
    input  wire cordic_t in_data,
    output logic         out_valid,
    output pose_out_t    out_data
);

    // Stage 1: cosine and sine from the quadrant, then the four products.
    logic signed [CW-1:0]  b1_cos, b1_sin, b1_x, b1_y;
    logic signed [31:0]    b1_dx, b1_dy;
    logic signed [CW+31:0] b1_xc_next, b1_xs_next, b1_yc_next, b1_ys_next;
    logic signed [CW+31:0] b1_xc_reg, b1_xs_reg, b1_yc_reg, b1_ys_reg;
    carry_t                b1_carry_reg;
    logic                  b1_valid_reg;

    always_comb
    begin
        b1_x  = in_data.x;
        b1_y  = in_data.y;
        b1_dx = in_data.carry.dx;
        b1_dy = in_data.carry.dy;
        unique case (in_data.carry.quad)
            QUAD_0:
            begin
                b1_cos = b1_x;
                b1_sin = b1_y;
            end
            QUAD_90:
            begin
                b1_cos = -b1_y;
                b1_sin = b1_x;
            end
            QUAD_180:
            begin
                b1_cos = -b1_x;
                b1_sin = -b1_y;
            end
            QUAD_270:
            begin
                b1_cos = b1_y;
                b1_sin = -b1_x;
            end
            default:
            begin
                b1_cos = b1_x;
                b1_sin = b1_y;
            end
        endcase
        b1_xc_next = b1_dx * b1_cos;
        b1_xs_next = b1_dx * b1_sin;
        b1_yc_next = b1_dy * b1_cos;
        b1_ys_next = b1_dy * b1_sin;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b1_xc_reg    <= b1_xc_next;
            b1_xs_reg    <= b1_xs_next;
            b1_yc_reg    <= b1_yc_next;
            b1_ys_reg    <= b1_ys_next;
            b1_carry_reg <= in_data.carry;
        end
    end

    // Stage 2: world-frame displacement, rounded back to Q16.16.
    logic signed [CW+32:0] b2_sumx, b2_sumy, b2_shx, b2_shy;
    logic signed [39:0]    b2_wx_next, b2_wy_next, b2_wx_reg, b2_wy_reg;
    carry_t                b2_carry_reg;
    logic                  b2_valid_reg;

    always_comb
    begin
        b2_sumx    = b1_xc_reg - b1_ys_reg + ROT_HALF;
        b2_sumy    = b1_yc_reg + b1_xs_reg + ROT_HALF;
        b2_shx     = b2_sumx >>> 30;
        b2_shy     = b2_sumy >>> 30;
        b2_wx_next = b2_shx[39:0];
        b2_wy_next = b2_shy[39:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b2_wx_reg    <= b2_wx_next;
            b2_wy_reg    <= b2_wy_next;
            b2_carry_reg <= b1_carry_reg;
        end
    end

    // Stage 3: add to the position, saturate, and hold the result beat.
    logic signed [31:0] b3_px, b3_py;
    sat_t               b3_satx, b3_saty;
    pose_out_t          b3_data_next, b3_data_reg;
    logic               b3_valid_reg;

    always_comb
    begin
        b3_px   = b2_carry_reg.px;
        b3_py   = b2_carry_reg.py;
        b3_satx = sat32(b3_px + b2_wx_reg);
        b3_saty = sat32(b3_py + b2_wy_reg);
        b3_data_next.new_x       = b3_satx.val;
        b3_data_next.new_y       = b3_saty.val;
        b3_data_next.new_heading = b2_carry_reg.nh;
        b3_data_next.overflow    = b2_carry_reg.ovf | b3_satx.of | b3_saty.of;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b3_data_reg <= b3_data_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg <= 1'b0;
            b2_valid_reg <= 1'b0;
            b3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            b1_valid_reg <= in_valid;
            b2_valid_reg <= b1_valid_reg;
            b3_valid_reg <= b2_valid_reg;
        end
    end

    assign out_valid = b3_valid_reg;
    assign out_data  = b3_data_reg;

endmodule

`default_nettype wire

[rtl/dead_reckon_pose.sv]
// Top level of the 2D dead reckoning pose predictor.
// Depends on drp_pkg, drp_front, drp_cordic_cell and drp_back.
//
// Usage:
// - Input channel pose_valid / pose_stall / pose carries one pose, body-frame
//   velocity and time step per beat. A beat is taken at a rising edge with
//   pose_valid high and pose_stall low.
// - Output channel result_valid / result_stall / result returns one predicted
//   pose with its overflow flag per input beat, in input order.
// - The datapath is one pipeline: four front stages (scaling, phase, quadrant,
//   angle seed), a row of CORDIC_STEPS rotation cells, and three back stages
//   (products, rounding, saturating add with the result register).
// - Throughput is one beat per cycle while no result is stalled; the pipeline
//   depth is set by the number of CORDIC cells, each doing one micro-rotation per cycle.
// - When the receiver stalls a valid result, the whole pipeline holds and
//   pose_stall is raised in the same cycle; the result beat stays unchanged.
// - Reset clears every stage valid bit; data registers are not reset.
`default_nettype none

module dead_reckon_pose
    import drp_pkg::*;
#(
    parameter int CORDIC_STEPS = 16,
    parameter int FRAC_BITS    = 16
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      pose_valid,
    output logic           pose_stall,
    input  wire pose_in_t  pose,
    output logic           result_valid,
    input  wire logic      result_stall,
    output pose_out_t      result
);

    // The pipeline advances unless a finished result is held by the receiver.
    logic    en;
    logic    chain_valid [CORDIC_STEPS+1];
    cordic_t chain_data  [CORDIC_STEPS+1];

    assign en         = !(result_valid && result_stall);
    assign pose_stall = !en;

    drp_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (pose_valid),
        .in_data   (pose),
        .out_valid (chain_valid[0]),
        .out_data  (chain_data[0])
    );

    // Row of CORDIC cells, one micro-rotation each.
    for (genvar g = 0; g < CORDIC_STEPS; g++)
    begin : g_cell
        drp_cordic_cell #(
            .STEP (g)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (chain_valid[g]),
            .in_data   (chain_data[g]),
            .out_valid (chain_valid[g+1]),
            .out_data  (chain_data[g+1])
        );
    end

    drp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (chain_valid[CORDIC_STEPS]),
        .in_data   (chain_data[CORDIC_STEPS]),
        .out_valid (result_valid),
        .out_data  (result)
    );

endmodule

`default_nettype wire

[rtl/drp_checker.sv]
// Port-level checks for dead_reckon_pose, attached by the bind at the end.
// Depends on drp_pkg and the top level's ports.
`default_nettype none

module drp_checker
    import drp_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      pose_valid,
    input wire logic      pose_stall,
    input wire logic      result_valid,
    input wire logic      result_stall,
    input wire pose_out_t result
);

    // A held result beat stays valid and unchanged.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=> (result_valid && $stable(result)))
        else $error("result beat changed while stalled");

    // The input side stalls exactly when the output side holds a beat.
    a_stall_link: assert property (@(posedge clk) disable iff (!rst_n)
        pose_stall == (result_valid && result_stall))
        else $error("input stall does not follow output back-pressure");

    // An offered pose is only stalled while a result beat sits on the port.
    a_frozen_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (pose_stall && pose_valid) |-> result_valid)
        else $error("input stalled without a held result");

    // Reset leaves no result on the port.
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !result_valid)
        else $error("result valid during reset");

endmodule

bind dead_reckon_pose drp_checker u_drp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .pose_valid   (pose_valid),
    .pose_stall   (pose_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

`default_nettype wire
